[src/longest_prefix_route_table_unit_defines.svh]
// Assertion macros for the route table RTL.
`ifndef LONGEST_PREFIX_ROUTE_TABLE_UNIT_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_TABLE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define LPRT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LPRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LPRT_ASSERT_IMPL(lbl, ante, cons, msg)
`define LPRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[src/lprt_pkg.sv]
// Types, codes and helper functions of the longest-prefix route table.
package lprt_pkg;

	localparam int ADDR_W = 32;
	localparam int LEN_W = 6;
	localparam int CNT_W = 7;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(32);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [ADDR_W-1:0] FULL_MASK = '1;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_LONGEST = 2'd1,
		REQ_EXACT = 2'd2,
		REQ_REMOVE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2,
		ST_DUP = 2'd3
	} stat_t;

	typedef struct packed {
		logic valid;
		logic [ADDR_W-1:0] network;
		logic [LEN_W-1:0] length;
		logic [ADDR_W-1:0] target;
	} entry_t;

	typedef struct packed {
		logic covers;
		logic exact;
		logic free;
	} match_t;

	function automatic logic [LEN_W-1:0] lprt_clamp(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] res;
		res = len;
		if (len == '0) begin
			res = LEN_W'(1);
		end else if (len > LEN_MAX) begin
			res = LEN_MAX;
		end
		return res;
	endfunction

	function automatic logic [ADDR_W-1:0] lprt_mask(input logic [LEN_W-1:0] len);
		logic [ADDR_W-1:0] res;
		res = '0;
		if (len != '0 && len <= LEN_MAX) begin
			res = FULL_MASK << (LEN_MAX - len);
		end
		return res;
	endfunction

endpackage

[src/lprt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lprt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[src/lprt_match.sv]
// Shared prefix compare unit that tests one table entry against the request.
module lprt_match (
	input lprt_pkg::entry_t entry,
	input logic [lprt_pkg::ADDR_W-1:0] addr,
	input logic [lprt_pkg::ADDR_W-1:0] net,
	input logic [lprt_pkg::LEN_W-1:0] len,
	output lprt_pkg::match_t result
);

	logic [lprt_pkg::ADDR_W-1:0] masked;
	logic len_ok;

	assign masked = addr & lprt_pkg::lprt_mask(entry.length);
	assign len_ok = (entry.length != '0) && (entry.length <= lprt_pkg::LEN_MAX);

	always_comb begin
		result.covers = entry.valid && len_ok && (entry.network == masked);
		result.exact = entry.valid && (entry.length == len) && (entry.network == net);
		result.free = !entry.valid;
	end

endmodule

[src/longest_prefix_route_table_unit.sv]
// Top level of the longest-prefix route table with its scan sequencer.
// The table lives in one RAM and every request scans all TABLE_ENTRIES entries through
// a single compare unit, one entry per cycle. After the scan an insert writes the new entry,
// if it is no duplicate and a free entry was found, in the S_WRITE state. A remove clears
// matching entries during the scan itself. After reset the block sweeps the RAM to clear
// every entry and keeps req_stall high meanwhile. A finished result waits in an output
// register, so the next request is taken while the previous result beat is still stalled.
`include "longest_prefix_route_table_unit_defines.svh"

module longest_prefix_route_table_unit #(
	parameter int TABLE_ENTRIES = 64
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input logic [1:0] req_type,
	input logic [31:0] address,
	input logic [5:0] prefix_len,
	input logic [31:0] ue_address,
	output logic rsp_valid,
	input logic rsp_stall,
	output logic [1:0] status,
	output logic [31:0] found_address,
	output logic [6:0] removed_count
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam int ENT_W = $bits(lprt_pkg::entry_t);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE = 5'b00010,
		S_SCAN = 5'b00100,
		S_WRITE = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0] rd_cnt_q;
	logic issue_q;
	logic cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;

	lprt_pkg::req_t req_q;
	logic [lprt_pkg::ADDR_W-1:0] addr_q;
	logic [lprt_pkg::ADDR_W-1:0] net_q;
	logic [lprt_pkg::LEN_W-1:0] len_q;
	logic [lprt_pkg::ADDR_W-1:0] ue_q;

	logic hit_q;
	logic [lprt_pkg::LEN_W-1:0] best_len_q;
	logic [lprt_pkg::ADDR_W-1:0] found_q;
	logic dup_q;
	logic free_vld_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [lprt_pkg::CNT_W-1:0] rm_cnt_q;

	logic rsp_valid_q;
	lprt_pkg::stat_t rsp_status_q;
	logic [lprt_pkg::ADDR_W-1:0] rsp_found_q;
	logic [lprt_pkg::CNT_W-1:0] rsp_count_q;

	logic accept;
	logic load_rsp;
	logic scan_end;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	lprt_pkg::entry_t wr_entry;
	logic [ENT_W-1:0] rd_data;
	lprt_pkg::entry_t rd_entry;
	lprt_pkg::match_t m;
	logic [lprt_pkg::LEN_W-1:0] len_in;

	assign req_stall = (state_q != S_IDLE);
	assign accept = req_valid && !req_stall;
	assign load_rsp = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);
	assign scan_end = (state_q == S_SCAN) && cmp_vld_s1 && (cmp_idx_s1 == LAST_IDX);
	assign len_in = lprt_pkg::lprt_clamp(prefix_len);
	assign rd_entry = lprt_pkg::entry_t'(rd_data);

	lprt_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_addr(rd_cnt_q),
		.rd_data(rd_data)
	);

	lprt_match u_match (
		.entry(rd_entry),
		.addr(addr_q),
		.net(net_q),
		.len(len_q),
		.result(m)
	);

	always_comb begin
		wr_en = 1'b0;
		wr_addr = rd_cnt_q;
		wr_entry = '0;
		unique case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_SCAN: begin
				wr_en = cmp_vld_s1 && (req_q == lprt_pkg::REQ_REMOVE) && m.covers;
				wr_addr = cmp_idx_s1;
				wr_entry = rd_entry;
				wr_entry.valid = 1'b0;
			end
			S_WRITE: begin
				wr_en = !dup_q && free_vld_q;
				wr_addr = free_idx_q;
				wr_entry.valid = 1'b1;
				wr_entry.network = net_q;
				wr_entry.length = len_q;
				wr_entry.target = ue_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			rd_cnt_q <= '0;
			issue_q <= 1'b0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == S_SCAN) && issue_q;
			unique case (state_q)
				S_CLEAR: begin
					rd_cnt_q <= rd_cnt_q + IDX_W'(1);
					if (rd_cnt_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						rd_cnt_q <= '0;
						issue_q <= 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue_q) begin
						rd_cnt_q <= rd_cnt_q + IDX_W'(1);
						if (rd_cnt_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end
					end
					if (scan_end) begin
						state_q <= (req_q == lprt_pkg::REQ_INSERT) ? S_WRITE : S_DONE;
					end
				end
				S_WRITE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_rsp) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_cnt_q;
		if (accept) begin
			req_q <= lprt_pkg::req_t'(req_type);
			addr_q <= address;
			len_q <= len_in;
			net_q <= address & lprt_pkg::lprt_mask(len_in);
			ue_q <= ue_address;
			hit_q <= 1'b0;
			best_len_q <= '0;
			found_q <= '0;
			dup_q <= 1'b0;
			free_vld_q <= 1'b0;
			free_idx_q <= '0;
			rm_cnt_q <= '0;
		end else if (state_q == S_SCAN && cmp_vld_s1) begin
			unique case (req_q)
				lprt_pkg::REQ_INSERT: begin
					if (m.exact) begin
						dup_q <= 1'b1;
					end
					if (m.free && !free_vld_q) begin
						free_vld_q <= 1'b1;
						free_idx_q <= cmp_idx_s1;
					end
				end
				lprt_pkg::REQ_LONGEST: begin
					if (m.covers && rd_entry.length > best_len_q) begin
						best_len_q <= rd_entry.length;
						found_q <= rd_entry.target;
						hit_q <= 1'b1;
					end
				end
				lprt_pkg::REQ_EXACT: begin
					if (m.exact && !hit_q) begin
						found_q <= rd_entry.target;
						hit_q <= 1'b1;
					end
				end
				lprt_pkg::REQ_REMOVE: begin
					if (m.covers && rm_cnt_q != lprt_pkg::CNT_MAX) begin
						rm_cnt_q <= rm_cnt_q + lprt_pkg::CNT_W'(1);
					end
				end
				default: begin
					hit_q <= hit_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_found_q <= '0;
			rsp_count_q <= '0;
			unique case (req_q)
				lprt_pkg::REQ_INSERT: begin
					if (dup_q) begin
						rsp_status_q <= lprt_pkg::ST_DUP;
					end else if (free_vld_q) begin
						rsp_status_q <= lprt_pkg::ST_OK;
					end else begin
						rsp_status_q <= lprt_pkg::ST_FULL;
					end
				end
				lprt_pkg::REQ_LONGEST, lprt_pkg::REQ_EXACT: begin
					rsp_status_q <= hit_q ? lprt_pkg::ST_OK : lprt_pkg::ST_MISS;
					rsp_found_q <= found_q;
				end
				lprt_pkg::REQ_REMOVE: begin
					rsp_status_q <= (rm_cnt_q != '0) ? lprt_pkg::ST_OK : lprt_pkg::ST_MISS;
					rsp_count_q <= rm_cnt_q;
				end
				default: begin
					rsp_status_q <= lprt_pkg::ST_MISS;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = rsp_status_q;
	assign found_address = rsp_found_q;
	assign removed_count = rsp_count_q;

	`LPRT_ASSERT_NEXT(a_accept_scan, accept, state_q == S_SCAN, "accepted beat left scan idle")
	`LPRT_ASSERT_IMPL(a_no_idle_write, state_q == S_IDLE, !wr_en, "table written while idle")
	`LPRT_ASSERT_IMPL(a_rsp_from_done, $rose(rsp_valid), $past(state_q == S_DONE), "early beat")
	`LPRT_ASSERT_IMPL(a_count_ok, rsp_valid && removed_count != '0, status == lprt_pkg::ST_OK, "bad count")

endmodule

[dv/longest_prefix_route_table_unit_test.sv]
// Self-checking testbench of the longest-prefix route table with random request gaps and response stalls.
module longest_prefix_route_table_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_ENTRIES = 64;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct packed {
		lprt_pkg::stat_t status;
		logic [31:0] found;
		logic [6:0] removed;
	} route_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [1:0] req_type = lprt_pkg::REQ_INSERT;
	logic [31:0] address = '0;
	logic [5:0] prefix_len = '0;
	logic [31:0] ue_address = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [1:0] status;
	logic [31:0] found_address;
	logic [6:0] removed_count;

	logic route_valid [TABLE_ENTRIES];
	logic [31:0] route_net [TABLE_ENTRIES];
	logic [5:0] route_len [TABLE_ENTRIES];
	logic [31:0] route_target [TABLE_ENTRIES];
	logic [31:0] base_pool [8];

	route_result_t expected_results [$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	bit idle_on = 1'b1;

	longest_prefix_route_table_unit #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.address(address),
		.prefix_len(prefix_len),
		.ue_address(ue_address),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.found_address(found_address),
		.removed_count(removed_count)
	);

	always #2 clk = ~clk;

	function automatic logic [31:0] prefix_mask(input int unsigned len);
		if (len == 0) begin
			return '0;
		end
		return 32'hffff_ffff << (32 - len);
	endfunction

	function automatic int find_route_key(input logic [31:0] net, input logic [5:0] len);
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (route_valid[i] && route_len[i] == len && route_net[i] == net) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic bit route_covers(input int idx, input logic [31:0] addr);
		return route_valid[idx] && route_net[idx] == (addr & prefix_mask(route_len[idx]));
	endfunction

	function automatic int stored_count();
		int n;
		n = 0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (route_valid[i]) begin
				n++;
			end
		end
		return n;
	endfunction

	function automatic route_result_t route_model_step(input lprt_pkg::req_t kind,
			input logic [31:0] addr, input logic [5:0] raw_len, input logic [31:0] ue);
		route_result_t res;
		logic [5:0] len;
		logic [5:0] best;
		logic [31:0] net;
		int slot;
		bit placed;
		res.status = lprt_pkg::ST_MISS;
		res.found = '0;
		res.removed = '0;
		len = raw_len;
		if (raw_len == 6'd0) begin
			len = 6'd1;
		end else if (raw_len > 6'd32) begin
			len = 6'd32;
		end
		net = addr & prefix_mask(len);
		case (kind)
			lprt_pkg::REQ_INSERT: begin
				if (find_route_key(net, len) >= 0) begin
					res.status = lprt_pkg::ST_DUP;
				end else begin
					res.status = lprt_pkg::ST_FULL;
					placed = 1'b0;
					for (int i = 0; i < TABLE_ENTRIES; i++) begin
						if (!placed && !route_valid[i]) begin
							placed = 1'b1;
							route_valid[i] = 1'b1;
							route_net[i] = net;
							route_len[i] = len;
							route_target[i] = ue;
							res.status = lprt_pkg::ST_OK;
						end
					end
				end
			end
			lprt_pkg::REQ_LONGEST: begin
				best = '0;
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (route_covers(i, addr) && route_len[i] > best) begin
						best = route_len[i];
						res.found = route_target[i];
						res.status = lprt_pkg::ST_OK;
					end
				end
			end
			lprt_pkg::REQ_EXACT: begin
				slot = find_route_key(net, len);
				if (slot >= 0) begin
					res.status = lprt_pkg::ST_OK;
					res.found = route_target[slot];
				end
			end
			default: begin
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (route_covers(i, addr)) begin
						route_valid[i] = 1'b0;
						if (res.removed != 7'h7f) begin
							res.removed = res.removed + 7'd1;
						end
					end
				end
				res.status = res.removed != '0 ? lprt_pkg::ST_OK : lprt_pkg::ST_MISS;
			end
		endcase
		return res;
	endfunction

	function automatic int draw_gap();
		return idle_on ? $urandom_range(0, 13) : 0;
	endfunction

	function automatic logic [31:0] pick_address();
		int unsigned roll;
		int unsigned keep;
		roll = $urandom_range(0, 15);
		if (roll == 0) begin
			return $urandom;
		end else if (roll == 1) begin
			return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
		end
		keep = $urandom_range(0, 32);
		return base_pool[$urandom_range(0, 7)] ^ ($urandom & ~prefix_mask(keep));
	endfunction

	function automatic logic [5:0] pick_len();
		int unsigned roll;
		roll = $urandom_range(0, 15);
		if (roll == 0) begin
			return 6'd0;
		end else if (roll == 1) begin
			return 6'($urandom_range(33, 63));
		end
		return 6'($urandom_range(1, 32));
	endfunction

	function automatic bit pick_stored(output logic [31:0] net, output logic [5:0] len);
		int k;
		net = '0;
		len = '0;
		if (stored_count() == 0) begin
			return 1'b0;
		end
		k = $urandom_range(0, stored_count() - 1);
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (route_valid[i]) begin
				if (k == 0) begin
					net = route_net[i];
					len = route_len[i];
				end
				k--;
			end
		end
		return 1'b1;
	endfunction

	task automatic reseed_bases();
		for (int i = 0; i < 8; i++) begin
			base_pool[i] = $urandom;
		end
	endtask

	task automatic send_request(input lprt_pkg::req_t kind, input logic [31:0] addr,
			input logic [5:0] len, input logic [31:0] ue);
		int gap;
		route_result_t res;
		gap = draw_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= kind;
		address <= addr;
		prefix_len <= len;
		ue_address <= ue;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		res = route_model_step(kind, addr, len, ue);
		expected_results.push_back(res);
	endtask

	task automatic send_random_item(input int w_ins, input int w_lng, input int w_exa,
			input int w_rem);
		int roll;
		lprt_pkg::req_t kind;
		logic [31:0] addr;
		logic [31:0] ue;
		logic [31:0] snet;
		logic [5:0] len;
		logic [5:0] slen;
		roll = $urandom_range(0, w_ins + w_lng + w_exa + w_rem - 1);
		if (roll < w_ins) begin
			kind = lprt_pkg::REQ_INSERT;
		end else if (roll < w_ins + w_lng) begin
			kind = lprt_pkg::REQ_LONGEST;
		end else if (roll < w_ins + w_lng + w_exa) begin
			kind = lprt_pkg::REQ_EXACT;
		end else begin
			kind = lprt_pkg::REQ_REMOVE;
		end
		addr = pick_address();
		len = pick_len();
		case ($urandom_range(0, 7))
			0: ue = '0;
			1: ue = '1;
			default: ue = $urandom;
		endcase
		if ((kind == lprt_pkg::REQ_INSERT && $urandom_range(0, 5) == 0) ||
				(kind == lprt_pkg::REQ_EXACT && $urandom_range(0, 1) == 0)) begin
			if (pick_stored(snet, slen)) begin
				addr = snet | ($urandom & ~prefix_mask(slen));
				len = slen;
			end
		end
		send_request(kind, addr, len, ue);
	endtask

	task automatic clear_table();
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (route_valid[i]) begin
				send_request(lprt_pkg::REQ_REMOVE,
					route_net[i] | ($urandom & ~prefix_mask(route_len[i])),
					6'($urandom), $urandom);
			end
		end
	endtask

	task automatic test_empty_table();
		send_request(lprt_pkg::REQ_LONGEST, 32'hffff_ffff, 6'd32, 32'h0);
		send_request(lprt_pkg::REQ_EXACT, 32'h0, 6'd0, 32'hffff_ffff);
		send_request(lprt_pkg::REQ_REMOVE, 32'h0, 6'd63, 32'h0);
	endtask

	task automatic test_insert_and_clamp();
		send_request(lprt_pkg::REQ_INSERT, 32'hffff_ffff, 6'd0, 32'hffff_ffff);
		send_request(lprt_pkg::REQ_INSERT, 32'h0000_0000, 6'd1, 32'h0);
		send_request(lprt_pkg::REQ_EXACT, 32'h7fff_ffff, 6'd1, 32'h0);
		send_request(lprt_pkg::REQ_INSERT, 32'hffff_ffff, 6'd63, 32'h1234_5678);
		send_request(lprt_pkg::REQ_EXACT, 32'hffff_ffff, 6'd32, 32'h0);
		send_request(lprt_pkg::REQ_EXACT, 32'hffff_ffff, 6'd40, 32'h0);
		send_request(lprt_pkg::REQ_INSERT, 32'h8000_0000, 6'd1, 32'h5555_aaaa);
		send_request(lprt_pkg::REQ_INSERT, 32'hc0a8_00ff, 6'd16, 32'h0a00_0001);
		send_request(lprt_pkg::REQ_INSERT, 32'hc0a8_0107, 6'd24, 32'h0a00_0002);
	endtask

	task automatic test_longest_match();
		send_request(lprt_pkg::REQ_LONGEST, 32'hc0a8_0105, 6'd0, 32'h0);
		send_request(lprt_pkg::REQ_LONGEST, 32'hc0a8_ff01, 6'd63, 32'h0);
		send_request(lprt_pkg::REQ_LONGEST, 32'h0000_0001, 6'd5, 32'h0);
		send_request(lprt_pkg::REQ_LONGEST, 32'hffff_ffff, 6'd1, 32'h0);
		send_request(lprt_pkg::REQ_LONGEST, 32'h8000_0000, 6'd32, 32'h0);
	endtask

	task automatic test_remove_covering();
		send_request(lprt_pkg::REQ_REMOVE, 32'hc0a8_0105, 6'd0, 32'h0);
		send_request(lprt_pkg::REQ_LONGEST, 32'hc0a8_0105, 6'd0, 32'h0);
		send_request(lprt_pkg::REQ_REMOVE, 32'h0000_0000, 6'd32, 32'h0);
		send_request(lprt_pkg::REQ_REMOVE, 32'hffff_ffff, 6'd32, 32'hffff_ffff);
		send_request(lprt_pkg::REQ_REMOVE, 32'hffff_ffff, 6'd32, 32'h0);
	endtask

	task automatic test_table_full();
		logic [31:0] snet;
		logic [5:0] slen;
		clear_table();
		reseed_bases();
		while (stored_count() < TABLE_ENTRIES) begin
			send_random_item(1, 0, 0, 0);
		end
		repeat (3) send_random_item(1, 0, 0, 0);
		if (pick_stored(snet, slen)) begin
			send_request(lprt_pkg::REQ_INSERT, snet, slen, $urandom);
		end
		repeat (6) send_random_item(0, 1, 1, 0);
		clear_table();
	endtask

	task automatic test_route_churn();
		reseed_bases();
		repeat (600) send_random_item(35, 30, 20, 15);
	endtask

	task automatic test_fill_pressure();
		reseed_bases();
		repeat (400) send_random_item(55, 20, 15, 10);
	endtask

	task automatic test_back_to_back();
		clear_table();
		reseed_bases();
		idle_on = 1'b0;
		repeat (200) send_random_item(40, 25, 20, 15);
		idle_on = 1'b1;
	endtask

	task automatic test_random_noise();
		repeat (350) begin
			send_request(lprt_pkg::req_t'($urandom_range(0, 3)), $urandom,
				6'($urandom_range(0, 63)), $urandom);
		end
	endtask

	initial begin
		int hold;
		forever begin
			hold = draw_gap();
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		route_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result beat with no request pending, status %0d found %h removed %0d",
					$time, status, found_address, removed_count);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
					mismatch_count++;
				end
				if (found_address !== want.found) begin
					$display("%0t: found_address expected %h actual %h", $time, want.found,
						found_address);
					mismatch_count++;
				end
				if (removed_count !== want.removed) begin
					$display("%0t: removed_count expected %0d actual %0d", $time, want.removed,
						removed_count);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("longest_prefix_route_table_unit_test: done, errors");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			route_valid[i] = 1'b0;
			route_net[i] = '0;
			route_len[i] = '0;
			route_target[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_table();
		test_insert_and_clamp();
		test_longest_match();
		test_remove_covering();
		test_table_full();
		test_route_churn();
		test_fill_pressure();
		test_back_to_back();
		test_random_noise();
		req_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("longest_prefix_route_table_unit_test: done, clean");
		end else begin
			$display("longest_prefix_route_table_unit_test: done, errors");
		end
		$finish;
	end

endmodule

[longest_prefix_route_table_unit.f]
+incdir+src
src/lprt_pkg.sv
src/lprt_ram.sv
src/lprt_match.sv
src/longest_prefix_route_table_unit.sv
dv/longest_prefix_route_table_unit_test.sv
